>>> rtl/fir_pkg.sv
`timescale 1ns / 1ps
// Package for the integer-to-radix text formatter.
// Holds transaction types, controller states, command and status structs, and constants.
package fir_pkg;

    localparam int VALUE_W     = 32;
    localparam int RADIX_W     = 6;
    localparam int DIGIT_W     = 6;
    localparam int CHAR_W      = 8;
    localparam int ADDR_W      = $clog2(VALUE_W);
    localparam int COUNT_W     = $clog2(VALUE_W + 1);
    localparam int DIV_BITS    = 8;
    localparam int DIV_CHUNKS  = VALUE_W / DIV_BITS;
    localparam int STEP_W      = $clog2(DIV_CHUNKS);

    localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_A     = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ERROR = 8'h00;

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_BAD_RADIX = 1'b1;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [RADIX_W-1:0]        radix;
    } fir_in_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last;
        logic              status;
    } fir_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_STORE,
        ST_SIGN,
        ST_FETCH,
        ST_EMIT,
        ST_ERROR
    } fir_state_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic store_digit;
        logic emit_sign;
        logic emit_digit;
        logic emit_error;
    } fir_cmd_t;

    typedef struct packed {
        logic radix_ok;
        logic chunk_done;
        logic quot_zero;
        logic neg;
        logic last_digit;
    } fir_stat_t;

    function automatic logic [CHAR_W-1:0] char_of_digit(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] d_ext;
        d_ext = CHAR_W'(d);
        if (d < DIGIT_W'(10))
            return CHAR_ZERO + d_ext;
        else
            return CHAR_A + d_ext - CHAR_W'(10);
    endfunction

endpackage

>>> rtl/fir_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine for the integer-to-radix text formatter.
// Depends on fir_pkg; drives commands to fir_datapath and reads its status.
module fir_ctrl
    import fir_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  fir_stat_t stat,
    output fir_cmd_t  cmd,
    output logic      busy
);

    fir_state_t state_reg;
    fir_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                    state_next = stat.radix_ok ? ST_DIVIDE : ST_ERROR;
            end
            ST_DIVIDE:
            begin
                if (stat.chunk_done)
                    state_next = ST_STORE;
            end
            ST_STORE:
            begin
                if (stat.quot_zero)
                    state_next = stat.neg ? ST_SIGN : ST_FETCH;
                else
                    state_next = ST_DIVIDE;
            end
            ST_SIGN:  state_next = ST_EMIT;
            ST_FETCH: state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (stat.last_digit)
                    state_next = ST_IDLE;
            end
            ST_ERROR: state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_DIVIDE: cmd.div_step    = 1'b1;
            ST_STORE:  cmd.store_digit = 1'b1;
            ST_SIGN:   cmd.emit_sign   = 1'b1;
            ST_FETCH:  cmd             = '0;
            ST_EMIT:   cmd.emit_digit  = 1'b1;
            ST_ERROR:  cmd.emit_error  = 1'b1;
            default:   busy            = 1'b0;
        endcase
    end

endmodule

>>> rtl/fir_datapath.sv
`timescale 1ns / 1ps
// Datapath for the integer-to-radix text formatter: magnitude, radix divider, digit store.
// Depends on fir_pkg; controlled by fir_ctrl through fir_cmd_t and fir_stat_t.
module fir_datapath
    import fir_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  fir_in_t   operand,
    input  fir_cmd_t  cmd,
    output fir_stat_t stat,
    output fir_out_t  result,
    output logic      strobe
);

    logic [DIGIT_W-1:0] digit_store [VALUE_W];

    logic [VALUE_W-1:0] div_reg,   div_next;
    logic [DIGIT_W-1:0] rem_reg,   rem_next;
    logic [RADIX_W-1:0] radix_reg, radix_next;
    logic               neg_reg,   neg_next;
    logic [STEP_W-1:0]  step_reg,  step_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [ADDR_W-1:0]  idx_reg,   idx_next;
    logic [DIGIT_W-1:0] rd_data_reg;
    fir_out_t           result_reg, result_next;
    logic               strobe_reg, strobe_next;

    logic [VALUE_W-1:0] magnitude;
    logic [VALUE_W-1:0] chunk_div;
    logic [DIGIT_W-1:0] chunk_rem;
    logic [ADDR_W-1:0]  rd_addr;

    assign magnitude = operand.value[VALUE_W-1] ? (~operand.value + VALUE_W'(1))
                                                : operand.value;

    // Restoring division, DIV_BITS quotient bits per cycle.
    always_comb
    begin
        logic [DIGIT_W:0]   trial;
        logic [VALUE_W-1:0] d;
        logic [DIGIT_W-1:0] r;
        logic               ge;
        d = div_reg;
        r = rem_reg;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            trial = {r, d[VALUE_W-1]};
            ge    = (trial >= {1'b0, radix_reg});
            r     = ge ? DIGIT_W'(trial - {1'b0, radix_reg}) : trial[DIGIT_W-1:0];
            d     = {d[VALUE_W-2:0], ge};
        end
        chunk_div = d;
        chunk_rem = r;
    end

    always_comb
    begin
        div_next    = div_reg;
        rem_next    = rem_reg;
        radix_next  = radix_reg;
        neg_next    = neg_reg;
        step_next   = step_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        result_next = result_reg;
        strobe_next = 1'b0;
        if (cmd.load)
        begin
            div_next   = magnitude;
            rem_next   = '0;
            radix_next = operand.radix;
            neg_next   = operand.value[VALUE_W-1];
            step_next  = '0;
            count_next = '0;
        end
        if (cmd.div_step)
        begin
            div_next  = chunk_div;
            rem_next  = chunk_rem;
            step_next = step_reg + STEP_W'(1);
        end
        if (cmd.store_digit)
        begin
            rem_next   = '0;
            step_next  = '0;
            count_next = count_reg + COUNT_W'(1);
            idx_next   = count_reg[ADDR_W-1:0];
        end
        if (cmd.emit_sign)
        begin
            result_next = '{char_code: CHAR_MINUS, last: 1'b0, status: STATUS_OK};
            strobe_next = 1'b1;
        end
        if (cmd.emit_digit)
        begin
            result_next = '{char_code: char_of_digit(rd_data_reg),
                            last: (idx_reg == '0), status: STATUS_OK};
            idx_next    = idx_reg - ADDR_W'(1);
            strobe_next = 1'b1;
        end
        if (cmd.emit_error)
        begin
            result_next = '{char_code: CHAR_ERROR, last: 1'b1, status: STATUS_BAD_RADIX};
            strobe_next = 1'b1;
        end
    end

    // Read ahead one entry while emitting.
    assign rd_addr = cmd.emit_digit ? (idx_reg - ADDR_W'(1)) : idx_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.store_digit)
            digit_store[count_reg[ADDR_W-1:0]] <= rem_reg;
        rd_data_reg <= digit_store[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        div_reg    <= div_next;
        rem_reg    <= rem_next;
        radix_reg  <= radix_next;
        neg_reg    <= neg_next;
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= '0;
            count_reg  <= '0;
            idx_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            step_reg   <= step_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            strobe_reg <= strobe_next;
        end
    end

    assign stat.radix_ok   = operand.radix inside {[RADIX_MIN:RADIX_MAX]};
    assign stat.chunk_done = (step_reg == STEP_W'(DIV_CHUNKS - 1));
    assign stat.quot_zero  = (div_reg == '0);
    assign stat.neg        = neg_reg;
    assign stat.last_digit = (idx_reg == '0);

    assign result = result_reg;
    assign strobe = strobe_reg;

endmodule

>>> rtl/format_integer_radix_unit.sv
`timescale 1ns / 1ps
// Top level of the integer-to-radix text formatter; joins fir_ctrl and fir_datapath.
// Each digit runs the divider over 8-bit chunks (ST_DIVIDE), then a store (ST_STORE); after
// the last store comes a fetch or sign state, then one character per cycle, sign first for a
// negative value. A new transaction is taken only when busy is low, after the previous one
// ends; a bad radix gives one error character. The result strobe cannot be stalled by the receiver.
// Reset: rst_n clears the controller to idle and drops strobe; digit store is not cleared.
module format_integer_radix_unit
    import fir_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  fir_in_t  operand,
    output logic     busy,
    output logic     strobe,
    output fir_out_t result
);

    fir_cmd_t  cmd;
    fir_stat_t stat;

    fir_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    fir_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .operand (operand),
        .cmd     (cmd),
        .stat    (stat),
        .result  (result),
        .strobe  (strobe)
    );

endmodule

>>> rtl/fir_checker.sv
`timescale 1ns / 1ps
// Port-level checker for format_integer_radix_unit, attached by bind.
// Depends on fir_pkg for the transaction types and character constants.
module fir_checker
    import fir_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     start,
    input logic     busy,
    input logic     strobe,
    input fir_out_t result
);

    a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.status |-> result.last)
        else $error("error transaction not marked last");

    a_error_char: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.status |-> result.char_code == CHAR_ERROR)
        else $error("error transaction carries a character");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not raise busy");

    a_text_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !result.last |=> strobe)
        else $error("gap inside a text transaction");

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !busy && !$past(busy) |-> !strobe)
        else $error("result strobe while idle");

endmodule

bind format_integer_radix_unit fir_checker u_fir_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .strobe  (strobe),
    .result  (result)
);
